// ===== src/arpr_pkg.sv =====
// shared types, constants and frame builder for the arp request responder
// no dependencies
`default_nettype none

package arpr_pkg;

    localparam int HDR_BYTES    = 8;
    localparam int MIN_BYTES    = 28;
    localparam int FRAME_BYTES  = 42;
    localparam int FRAME_BITS   = FRAME_BYTES * 8;
    localparam int FRAME_IDX_W  = $clog2(FRAME_BYTES);
    localparam int COUNT_W      = 10;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // register indexes
    localparam logic [1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [1:0] REG_OWN_IP   = 2'd1;
    localparam logic [1:0] REG_IP_VALID = 2'd2;

    // protocol constants
    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
    localparam logic [15:0] HTYPE_ETH    = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  HLEN_ETH     = 8'd6;
    localparam logic [7:0]  PLEN_IPV4    = 8'd4;
    localparam logic [15:0] OP_REQUEST   = 16'h0001;
    localparam logic [15:0] OP_REPLY     = 16'h0002;

    // output kind flag
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_BIND  = 1'b1;

    // job handed from parser to emitter
    typedef struct packed {
        logic        is_bind;
        logic [47:0] mac;
        logic [31:0] ip;
    } arpr_cmd_t;

    // one byte of the reply frame, wire order
    function automatic logic [7:0] frame_byte(
        input logic [FRAME_IDX_W-1:0] idx,
        input logic [47:0]            peer_mac,
        input logic [31:0]            peer_ip,
        input logic [47:0]            my_mac,
        input logic [31:0]            my_ip
    );
        logic [FRAME_BITS-1:0] frame;
        logic [8:0]            base;
        frame = {peer_mac, my_mac, ETH_TYPE_ARP, HTYPE_ETH, PTYPE_IPV4,
                 HLEN_ETH, PLEN_IPV4, OP_REPLY, my_mac, my_ip, peer_mac, peer_ip};
        base  = 9'(FRAME_BITS - 1) - {idx, 3'b000};
        return frame[base -: 8];
    endfunction

endpackage

`default_nettype wire

// ===== src/arpr_parser.sv =====
// front end: captures arp fields byte by byte and classifies the packet
// depends on arpr_pkg
`default_nettype none

module arpr_parser
    import arpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] own_ip,
    input  wire logic        ip_valid,
    output arpr_cmd_t        cmd,
    output logic             cmd_valid,
    input  wire logic        cmd_ready
);

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [15:0]        htype_reg,  htype_next;
    logic [15:0]        ptype_reg,  ptype_next;
    logic [7:0]         hlen_reg,   hlen_next;
    logic [7:0]         plen_reg,   plen_next;
    logic [15:0]        op_reg,     op_next;
    logic [47:0]        smac_reg,   smac_next;
    logic [31:0]        sip_reg,    sip_next;
    logic [31:0]        tip_reg,    tip_next;
    logic               hdr_ok, is_req, is_rep, accept;

    // the queue slot is needed only at the end of a packet
    assign in_ready = cmd_ready;
    assign accept   = in_valid && in_ready;

    // field capture by byte position, current byte included
    always_comb
    begin
        htype_next = htype_reg;
        ptype_next = ptype_reg;
        hlen_next  = hlen_reg;
        plen_next  = plen_reg;
        op_next    = op_reg;
        smac_next  = smac_reg;
        sip_next   = sip_reg;
        tip_next   = tip_reg;
        if (count_reg < COUNT_W'(2))
            htype_next = {htype_reg[7:0], data_byte};
        else if (count_reg < COUNT_W'(4))
            ptype_next = {ptype_reg[7:0], data_byte};
        else if (count_reg == COUNT_W'(4))
            hlen_next = data_byte;
        else if (count_reg == COUNT_W'(5))
            plen_next = data_byte;
        else if (count_reg < COUNT_W'(HDR_BYTES))
            op_next = {op_reg[7:0], data_byte};
        else if (count_reg < COUNT_W'(14))
            smac_next = {smac_reg[39:0], data_byte};
        else if (count_reg < COUNT_W'(18))
            sip_next = {sip_reg[23:0], data_byte};
        else if (count_reg >= COUNT_W'(24) && count_reg < COUNT_W'(MIN_BYTES))
            tip_next = {tip_reg[23:0], data_byte};
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    end

    // end-of-packet classification
    always_comb
    begin
        hdr_ok = htype_next == HTYPE_ETH && hlen_next == HLEN_ETH
              && count_next >= COUNT_W'(MIN_BYTES)
              && ptype_next == PTYPE_IPV4 && plen_next == PLEN_IPV4;
        is_req = hdr_ok && op_next == OP_REQUEST && tip_next == own_ip && ip_valid;
        is_rep = hdr_ok && op_next == OP_REPLY;
        cmd.is_bind = is_rep;
        cmd.mac     = smac_next;
        cmd.ip      = sip_next;
        cmd_valid   = in_valid && last_byte && (is_req || is_rep);
    end

    // capture registers, cleared after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            htype_reg <= '0;
            ptype_reg <= '0;
            hlen_reg  <= '0;
            plen_reg  <= '0;
            op_reg    <= '0;
            smac_reg  <= '0;
            sip_reg   <= '0;
            tip_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                htype_reg <= '0;
                ptype_reg <= '0;
                hlen_reg  <= '0;
                plen_reg  <= '0;
                op_reg    <= '0;
                smac_reg  <= '0;
                sip_reg   <= '0;
                tip_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                htype_reg <= htype_next;
                ptype_reg <= ptype_next;
                hlen_reg  <= hlen_next;
                plen_reg  <= plen_next;
                op_reg    <= op_next;
                smac_reg  <= smac_next;
                sip_reg   <= sip_next;
                tip_reg   <= tip_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/arpr_cmd_fifo.sv =====
// short job queue between parser and emitter
// depends on arpr_pkg
`default_nettype none

module arpr_cmd_fifo
    import arpr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire arpr_cmd_t push_cmd,
    input  wire logic      push_valid,
    output logic           push_ready,
    output arpr_cmd_t      pop_cmd,
    output logic           pop_valid,
    input  wire logic      pop_ready
);

    arpr_cmd_t              mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   fill_reg;
    logic                   do_push, do_pop;

    assign push_ready = fill_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + (QUEUE_PTR_W+1)'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ===== src/arpr_emitter.sv =====
// back end: plays out reply frames and binding items into an output register
// depends on arpr_pkg
`default_nettype none

module arpr_emitter
    import arpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire arpr_cmd_t   cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [47:0] own_mac,
    input  wire logic [31:0] own_ip,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             out_kind,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic [31:0]      out_ip,
    output logic [47:0]      out_mac
);

    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic                   valid_reg;
    logic                   kind_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic [31:0]            ip_reg;
    logic [47:0]            mac_reg;
    logic                   load, end_of_job;

    // output register takes a new beat when empty or being drained
    assign load       = cmd_valid && (!valid_reg || out_ready);
    assign end_of_job = cmd.is_bind || idx_reg == FRAME_IDX_W'(FRAME_BYTES - 1);
    assign cmd_ready  = load && end_of_job;
    assign idx_next   = end_of_job ? '0 : idx_reg + FRAME_IDX_W'(1);

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_ip    = ip_reg;
    assign out_mac   = mac_reg;

    // control: frame index and beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // payload of the output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= end_of_job;
            if (cmd.is_bind)
            begin
                kind_reg <= KIND_BIND;
                byte_reg <= '0;
                ip_reg   <= cmd.ip;
                mac_reg  <= cmd.mac;
            end
            else
            begin
                kind_reg <= KIND_FRAME;
                byte_reg <= frame_byte(idx_reg, cmd.mac, cmd.ip, own_mac, own_ip);
                ip_reg   <= '0;
                mac_reg  <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/arp_request_responder.sv =====
// top level of the arp request responder: config registers, parser, queue, emitter
// depends on arpr_pkg, arpr_parser, arpr_cmd_fifo, arpr_emitter
//
// channel   dir  beat fields
// s_axis    in   tdata: data_byte[7:0]; tlast: last_byte
// m_axis    out  tdata: out_byte, peer_ip, peer_mac; tlast: out_last; tuser: kind
// cfg       in   cfg_index selects own_mac, own_ip, ip_valid; cfg_data carries value
//
// input bytes are taken one per cycle while the job queue is not full.
// a reply frame drains as 42 byte beats and a binding as a single beat, limited by the output register.
// up to four pending jobs sit in the queue; s_axis_tready drops only while it is full.
// reset clears the parser capture, queue pointers and the output valid; cfg_ready is
// always high.
`default_nettype none

module arp_request_responder
    import arpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // out_byte[7:0], peer_ip[39:8], peer_mac[87:40]
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // kind[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        ip_valid_reg;
    arpr_cmd_t   front_cmd, back_cmd;
    logic        front_valid, front_ready, back_valid, back_ready;
    logic [7:0]  out_byte;
    logic [31:0] out_ip;
    logic [47:0] out_mac;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {out_mac, out_ip, out_byte};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg  <= '0;
            own_ip_reg   <= '0;
            ip_valid_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_MAC:  own_mac_reg  <= cfg_data;
                REG_OWN_IP:   own_ip_reg   <= cfg_data[31:0];
                REG_IP_VALID: ip_valid_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // front end
    arpr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .own_ip    (own_ip_reg),
        .ip_valid  (ip_valid_reg),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // job queue
    arpr_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // back end
    arpr_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .own_mac   (own_mac_reg),
        .own_ip    (own_ip_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_byte  (out_byte),
        .out_last  (m_axis_tlast),
        .out_ip    (out_ip),
        .out_mac   (out_mac)
    );

endmodule

`default_nettype wire

// ===== dv/tb_arp_request_responder.sv =====
// self-checking testbench for arp_request_responder: directed and random arp packets
// depends on arpr_pkg and the arp_request_responder rtl; predicts every output beat itself

module tb_arp_request_responder;
    import arpr_pkg::*;

    // write to this index must be ignored by the block
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_BYTES   = 46;
    localparam int LONG_BYTES    = 1100;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_OWN_MAC;
    logic [47:0] cfg_data = 48'h0;

    // predictor copy of the registers
    logic [47:0] my_mac = 48'h0;
    logic [31:0] my_ip = 32'h0;
    logic        my_ip_valid = 1'b0;

    // predictor copy of the packet capture
    logic [9:0]  rx_count = 10'd0;
    logic [15:0] rx_hw_type = 16'h0;
    logic [15:0] rx_proto_type = 16'h0;
    logic [7:0]  rx_hw_len = 8'h0;
    logic [7:0]  rx_proto_len = 8'h0;
    logic [15:0] rx_opcode = 16'h0;
    logic [47:0] rx_sender_mac = 48'h0;
    logic [31:0] rx_sender_ip = 32'h0;
    logic [31:0] rx_target_ip = 32'h0;

    arp_beat_t   pending_beats[$];
    arp_beat_t   want;
    logic [7:0]  pkt[$];
    logic        no_idle = 1'b0;
    int          ready_hold = 0;
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;

    arp_request_responder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand48();
        logic [47:0] v;
        v[31:0]  = $urandom;
        v[47:32] = 16'($urandom);
        return v;
    endfunction

    // output side backpressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold--;
        else if (no_idle || $urandom_range(0, 99) < 65)
        begin
            m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 10);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    // compare each output beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected output beat: tdata %0h tlast %0b tuser %0b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("kind: expected %0h, got %0h", want.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== want.data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("out_last: expected %0h, got %0h", want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[39:8] !== want.ip)
                begin
                    $error("peer_ip: expected %0h, got %0h", want.ip, m_axis_tdata[39:8]);
                    fail_count++;
                end
                if (m_axis_tdata[87:40] !== want.mac)
                begin
                    $error("peer_mac: expected %0h, got %0h", want.mac, m_axis_tdata[87:40]);
                    fail_count++;
                end
            end
        end
    end

    task automatic clear_capture();
        rx_count      = 10'd0;
        rx_hw_type    = 16'h0;
        rx_proto_type = 16'h0;
        rx_hw_len     = 8'h0;
        rx_proto_len  = 8'h0;
        rx_opcode     = 16'h0;
        rx_sender_mac = 48'h0;
        rx_sender_ip  = 32'h0;
        rx_target_ip  = 32'h0;
    endtask

    // capture one payload byte and, on the last one, queue the beats it causes
    task automatic predict_arp_byte(input logic [7:0] b, input logic l);
        logic [9:0]            pos;
        logic                  good;
        logic [FRAME_BITS-1:0] frame;
        arp_beat_t             beat;
        int                    i;
        pos = rx_count;
        if (pos < 10'd2)
            rx_hw_type = {rx_hw_type[7:0], b};
        else if (pos < 10'd4)
            rx_proto_type = {rx_proto_type[7:0], b};
        else if (pos == 10'd4)
            rx_hw_len = b;
        else if (pos == 10'd5)
            rx_proto_len = b;
        else if (pos < 10'(HDR_BYTES))
            rx_opcode = {rx_opcode[7:0], b};
        else if (pos < 10'd14)
            rx_sender_mac = {rx_sender_mac[39:0], b};
        else if (pos < 10'd18)
            rx_sender_ip = {rx_sender_ip[23:0], b};
        else if (pos >= 10'd24 && pos < 10'(MIN_BYTES))
            rx_target_ip = {rx_target_ip[23:0], b};

        // count saturates instead of wrapping
        if (rx_count != COUNT_MAX)
            rx_count++;

        if (l)
        begin
            good = rx_hw_type == HTYPE_ETH && rx_hw_len == HLEN_ETH &&
                   rx_count >= 10'(MIN_BYTES) && rx_proto_type == PTYPE_IPV4 &&
                   rx_proto_len == PLEN_IPV4;
            if (good && rx_opcode == OP_REQUEST && rx_target_ip == my_ip && my_ip_valid)
            begin
                frame = {rx_sender_mac, my_mac, ETH_TYPE_ARP, HTYPE_ETH, PTYPE_IPV4,
                         HLEN_ETH, PLEN_IPV4, OP_REPLY, my_mac, my_ip,
                         rx_sender_mac, rx_sender_ip};
                for (i = 0; i < FRAME_BYTES; i++)
                begin
                    beat.kind = KIND_FRAME;
                    beat.data = frame[FRAME_BITS - 1 - 8 * i -: 8];
                    beat.last = (i == FRAME_BYTES - 1);
                    beat.ip   = 32'h0;
                    beat.mac  = 48'h0;
                    pending_beats.push_back(beat);
                end
            end
            else if (good && rx_opcode == OP_REPLY)
            begin
                beat.kind = KIND_BIND;
                beat.data = 8'h00;
                beat.last = 1'b1;
                beat.ip   = rx_sender_ip;
                beat.mac  = rx_sender_mac;
                pending_beats.push_back(beat);
            end
            clear_capture();
        end
    endtask

    // one config beat, predictor updated at the handshake
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_OWN_MAC:  my_mac = value;
            REG_OWN_IP:   my_ip = value[31:0];
            REG_IP_VALID: my_ip_valid = value[0];
            default:      ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one input beat; tvalid stays high after the handshake
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_arp_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // let every predicted beat drain, then let the design settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // well-formed ethernet/ipv4 arp payload, truncated or padded to len bytes
    task automatic build_arp(input logic [15:0] op, input logic [47:0] smac,
                             input logic [31:0] sip, input logic [31:0] tip, input int len);
        logic [8*MIN_BYTES-1:0] body;
        int                     i;
        body = {HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4, op, smac, sip, rand48(), tip};
        pkt.delete();
        for (i = 0; i < len; i++)
        begin
            if (i < MIN_BYTES)
                pkt.push_back(body[8 * MIN_BYTES - 1 - 8 * i -: 8]);
            else
                pkt.push_back(8'($urandom));
        end
    endtask

    task automatic corrupt_byte(input int idx);
        pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
    endtask

    // requests answered, with all-ones and all-zero addresses
    task automatic test_request_reply();
        write_reg(REG_OWN_MAC, {48{1'b1}});
        write_reg(REG_OWN_IP, {16'hA5C3, 32'hFFFF_FFFF});
        write_reg(REG_IP_VALID, 48'h1);
        build_arp(OP_REQUEST, {48{1'b1}}, 32'hFFFF_FFFF, my_ip, MIN_BYTES);
        send_pkt();
        build_arp(OP_REQUEST, 48'h0, 32'h0, my_ip, MIN_BYTES + 2);
        send_pkt();
        wait_idle();
        write_reg(REG_OWN_MAC, 48'h0);
        write_reg(REG_OWN_IP, 48'h0);
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip, MIN_BYTES);
        send_pkt();
        wait_idle();
    endtask

    // replies give one binding beat each
    task automatic test_reply_binding();
        build_arp(OP_REPLY, {48{1'b1}}, 32'hFFFF_FFFF, $urandom, MIN_BYTES);
        send_pkt();
        build_arp(OP_REPLY, 48'h0, 32'h0, $urandom, MIN_BYTES + 1);
        send_pkt();
        build_arp(OP_REPLY, rand48(), $urandom, $urandom, MIN_BYTES);
        send_pkt();
        wait_idle();
    endtask

    // packets that must be dropped, interleaved with packets that must not
    task automatic test_dropped();
        int off;
        write_reg(REG_OWN_MAC, rand48());
        write_reg(REG_OWN_IP, rand48());
        write_reg(REG_IP_VALID, 48'h1);
        // request for another ip
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip ^ 32'h1, MIN_BYTES);
        send_pkt();
        wait_idle();
        // ip_valid masked to bit 0, so no ip assigned
        write_reg(REG_IP_VALID, 48'h2);
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip, MIN_BYTES);
        send_pkt();
        wait_idle();
        // unused index leaves everything alone
        write_reg(REG_UNUSED, {48{1'b1}});
        write_reg(REG_IP_VALID, 48'h1);
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip, MIN_BYTES);
        send_pkt();
        // short packets: one byte, shorter than the header, one byte short
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip, 1);
        send_pkt();
        build_arp(OP_REPLY, rand48(), $urandom, my_ip, HDR_BYTES - 1);
        send_pkt();
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip, MIN_BYTES - 1);
        send_pkt();
        build_arp(OP_REPLY, rand48(), $urandom, $urandom, MIN_BYTES);
        send_pkt();
        // unknown opcodes
        build_arp(16'h0000, rand48(), $urandom, my_ip, MIN_BYTES);
        send_pkt();
        build_arp(16'h0003, rand48(), $urandom, my_ip, MIN_BYTES);
        send_pkt();
        build_arp(16'h0101, rand48(), $urandom, my_ip, MIN_BYTES);
        send_pkt();
        // wrong type or length in each header byte
        for (off = 0; off < 6; off++)
        begin
            build_arp(OP_REPLY, rand48(), $urandom, my_ip, MIN_BYTES);
            corrupt_byte(off);
            send_pkt();
        end
        build_arp(OP_REPLY, rand48(), $urandom, $urandom, MIN_BYTES);
        send_pkt();
        wait_idle();
    endtask

    // count must saturate, not wrap back over the header offsets
    task automatic test_long_packet();
        build_arp(OP_REQUEST, rand48(), $urandom, my_ip, LONG_BYTES);
        send_pkt();
        build_arp(OP_REPLY, rand48(), $urandom, $urandom, MIN_BYTES);
        send_pkt();
        wait_idle();
    endtask

    task automatic send_random_packet();
        int          pick;
        int          len;
        logic [31:0] tip;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_BYTES + 1, 40) : MIN_BYTES;
        tip  = ($urandom_range(0, 3) != 0) ? my_ip : $urandom;
        if (pick < 45)
            build_arp(OP_REQUEST, rand48(), $urandom, tip, len);
        else if (pick < 72)
            build_arp(OP_REPLY, rand48(), $urandom, tip, len);
        else if (pick < 84)
        begin
            build_arp(($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY,
                      rand48(), $urandom, tip, len);
            corrupt_byte($urandom_range(0, HDR_BYTES - 1));
        end
        else if (pick < 92)
            build_arp(OP_REQUEST, rand48(), $urandom, tip, $urandom_range(1, MIN_BYTES - 1));
        else
        begin
            pkt.delete();
            len = $urandom_range(1, 40);
            repeat (len) pkt.push_back(8'($urandom));
        end
        send_pkt();
    endtask

    // random phases, each with its own register setting and idle pattern
    task automatic test_random();
        int          phase;
        int          stop_at;
        int          r;
        logic [47:0] v;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            r = $urandom_range(0, 9);
            v = (r < 2) ? 48'h0 : (r < 4) ? {48{1'b1}} : rand48();
            write_reg(REG_OWN_MAC, v);
            r = $urandom_range(0, 9);
            v = (r < 2) ? 48'h0 : (r < 4) ? {48{1'b1}} : rand48();
            write_reg(REG_OWN_IP, v);
            v = rand48();
            v[0] = ($urandom_range(0, 9) < 7);
            write_reg(REG_IP_VALID, v);
            no_idle = ($urandom_range(0, 3) == 0);
            stop_at = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop_at)
                send_random_packet();
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        clear_capture();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_reply();
        test_reply_binding();
        test_dropped();
        test_long_packet();
        test_random();
        wait_idle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/arpr_pkg.sv
src/arpr_parser.sv
src/arpr_cmd_fifo.sv
src/arpr_emitter.sv
src/arp_request_responder.sv
dv/tb_arp_request_responder.sv
